// ----- rtl/lmfs_pkg.sv -----
// Shared constants, command codes and controller types of the LED matrix frame scanner.
`default_nettype none

package lmfs_pkg;

    // Frame geometry
    localparam int MAX_ROWS = 8;
    localparam int MAX_COLS = 8;
    localparam int ROW_IDX_W = $clog2(MAX_ROWS);
    localparam int CNT_W = 4;
    localparam int ROW_EN_W = 8;

    // Configuration register indexes
    localparam logic CFG_ROWS_IN_USE = 1'b0;
    localparam logic CFG_COLS_IN_USE = 1'b1;

    // Command codes
    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_LOAD_ROW    = 3'd1,
        OP_FILL_ONES   = 3'd2,
        OP_ROTATE_ROWS = 3'd3,
        OP_ROTATE_COLS = 3'd4,
        OP_MIRROR_COLS = 3'd5,
        OP_MIRROR_ROWS = 3'd6,
        OP_INVERT      = 3'd7
    } op_t;

    // Controller states
    typedef enum logic {
        ST_READY,
        ST_OUTPUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic exec;     // apply the word presented on the input channel
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;  // presented word is a scan tick and makes a result
    } dp_status_t;

endpackage : lmfs_pkg

`default_nettype wire

// ----- rtl/lmfs_ctrl.sv -----
// Handshake controller of the LED matrix frame scanner.
`default_nettype none

module lmfs_ctrl
    import lmfs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_READY;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and outputs
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            ST_READY: begin
                s_tready = 1'b1;
                cmd.exec = s_tvalid;
                if (s_tvalid && status.is_tick) begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                // result register frees up in the same cycle it is taken
                m_tvalid = 1'b1;
                s_tready = m_tready;
                cmd.exec = s_tvalid && m_tready;
                if (m_tready && !(s_tvalid && status.is_tick)) begin
                    state_next = ST_READY;
                end
            end
            default: begin
                state_next = ST_READY;
            end
        endcase
    end

endmodule : lmfs_ctrl

`default_nettype wire

// ----- rtl/lmfs_datapath.sv -----
// Frame store, configuration registers, row transforms and result register.
`default_nettype none

module lmfs_datapath
    import lmfs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [CNT_W-1:0]     cfg_wdata,
    input  wire logic [2:0]           operation,
    input  wire logic [ROW_IDX_W-1:0] row_index,
    input  wire logic [MAX_COLS-1:0]  row_data,
    input  wire ctrl_cmd_t            cmd,
    output dp_status_t                status,
    output logic [ROW_EN_W-1:0]       row_enable,
    output logic [MAX_COLS-1:0]       column_bits
);

    logic [CNT_W-1:0]     rows_cfg_reg;
    logic [CNT_W-1:0]     cols_cfg_reg;
    logic [MAX_COLS-1:0]  frame_reg [MAX_ROWS];
    logic [MAX_COLS-1:0]  frame_next [MAX_ROWS];
    logic [ROW_IDX_W-1:0] scan_row_reg;
    logic [ROW_IDX_W-1:0] scan_row_next;
    logic [ROW_EN_W-1:0]  row_enable_reg;
    logic [MAX_COLS-1:0]  column_bits_reg;

    logic [CNT_W-1:0]     rows_eff;
    logic [CNT_W-1:0]     cols_eff;
    logic [MAX_COLS-1:0]  col_mask;
    logic [ROW_IDX_W-1:0] tick_row;
    logic [CNT_W-1:0]     tick_row_inc;
    op_t                  op;

    assign op             = op_t'(operation);
    assign status.is_tick = (op == OP_TICK);

    // Clamp configuration to its usable range
    always_comb begin
        rows_eff = rows_cfg_reg;
        if (rows_eff == '0) rows_eff = CNT_W'(1);
        if (rows_eff > CNT_W'(MAX_ROWS)) rows_eff = CNT_W'(MAX_ROWS);
        cols_eff = cols_cfg_reg;
        if (cols_eff == '0) cols_eff = CNT_W'(1);
        if (cols_eff > CNT_W'(MAX_COLS)) cols_eff = CNT_W'(MAX_COLS);
    end

    assign col_mask = MAX_COLS'(({{MAX_COLS{1'b0}}, 1'b1} << cols_eff) - 1'b1);

    // Scan row select and advance; a stale row past rows in use restarts at zero
    assign tick_row     = ({1'b0, scan_row_reg} >= rows_eff) ? '0 : scan_row_reg;
    assign tick_row_inc = {1'b0, tick_row} + 1'b1;
    assign scan_row_next = (tick_row_inc >= rows_eff) ? '0 : tick_row_inc[ROW_IDX_W-1:0];

    // Next frame contents for each command
    always_comb begin
        logic [CNT_W-1:0]     src_cnt;
        logic [ROW_IDX_W-1:0] src_idx;
        logic [CNT_W-1:0]     bit_cnt;
        for (int i = 0; i < MAX_ROWS; i++) begin
            frame_next[i] = frame_reg[i];
            src_cnt = '0;
            src_idx = '0;
            bit_cnt = '0;
            unique case (op)
                OP_TICK: begin
                end
                OP_LOAD_ROW: begin
                    if (row_index == ROW_IDX_W'(i)) frame_next[i] = row_data & col_mask;
                end
                OP_FILL_ONES: begin
                    frame_next[i] = col_mask;
                end
                OP_ROTATE_ROWS: begin
                    if (CNT_W'(i) < rows_eff) begin
                        src_cnt = (i == 0) ? rows_eff - 1'b1 : CNT_W'(i - 1);
                        src_idx = src_cnt[ROW_IDX_W-1:0];
                        frame_next[i] = frame_reg[src_idx] & col_mask;
                    end
                end
                OP_ROTATE_COLS: begin
                    if (CNT_W'(i) < rows_eff) begin
                        bit_cnt = cols_eff - 1'b1;
                        frame_next[i] = ({frame_reg[i][MAX_COLS-2:0], 1'b0}
                                         | MAX_COLS'(frame_reg[i][bit_cnt[2:0]]))
                                        & col_mask;
                    end
                end
                OP_MIRROR_COLS: begin
                    if (CNT_W'(i) < rows_eff) begin
                        for (int k = 0; k < MAX_COLS; k++) begin
                            bit_cnt = cols_eff - 1'b1 - CNT_W'(k);
                            frame_next[i][k] = (CNT_W'(k) < cols_eff)
                                               ? frame_reg[i][bit_cnt[2:0]] : 1'b0;
                        end
                    end
                end
                OP_MIRROR_ROWS: begin
                    if (CNT_W'(i) < rows_eff) begin
                        src_cnt = rows_eff - 1'b1 - CNT_W'(i);
                        src_idx = src_cnt[ROW_IDX_W-1:0];
                        frame_next[i] = frame_reg[src_idx] & col_mask;
                    end
                end
                OP_INVERT: begin
                    if (CNT_W'(i) < rows_eff) frame_next[i] = ~frame_reg[i] & col_mask;
                end
                default: begin
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= CNT_W'(MAX_ROWS);
            cols_cfg_reg <= CNT_W'(MAX_COLS);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ROWS_IN_USE: rows_cfg_reg <= cfg_wdata;
                CFG_COLS_IN_USE: cols_cfg_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Frame store and scan counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_ROWS; i++) frame_reg[i] <= '1;
            scan_row_reg <= '0;
        end else if (cmd.exec) begin
            for (int i = 0; i < MAX_ROWS; i++) frame_reg[i] <= frame_next[i];
            if (status.is_tick) scan_row_reg <= scan_row_next;
        end
    end

    // Result word register
    always_ff @(posedge aclk) begin
        if (cmd.exec && status.is_tick) begin
            row_enable_reg  <= ROW_EN_W'({{(ROW_EN_W-1){1'b0}}, 1'b1} << tick_row);
            column_bits_reg <= frame_reg[tick_row] & col_mask;
        end
    end

    assign row_enable  = row_enable_reg;
    assign column_bits = column_bits_reg;

endmodule : lmfs_datapath

`default_nettype wire

// ----- rtl/led_matrix_frame_scanner.sv -----
// Top level of the LED matrix frame scanner: stream ports, controller and datapath.
`default_nettype none

// Channel   Dir  Word fields (low bit up)
// s_        in   operation[2:0], row_index[5:3], row_data[13:6], zero pad[15:14]
// m_        out  row_enable[7:0], column_bits[15:8]
// cfg_      in   index 0 rows_in_use, index 1 cols_in_use, 4-bit data
//
// The whole frame sits in flip-flops and each command rewrites all the rows
// that it changes at once. Only a scan tick makes an output word, held in a
// result register; the next word is taken in the cycle that result drains,
// so back-to-back words flow at one per cycle while m_tready is high.
// Reset (synchronous, active low) fills the frame with ones, clears the scan
// row and sets both counts to eight.

module led_matrix_frame_scanner
    import lmfs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // operation, row_index, row_data, pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // row_enable, column_bits
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [3:0]  cfg_wdata
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic [ROW_EN_W-1:0] row_enable;
    logic [MAX_COLS-1:0] column_bits;

    lmfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lmfs_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .operation   (s_tdata[2:0]),
        .row_index   (s_tdata[5:3]),
        .row_data    (s_tdata[13:6]),
        .cmd         (cmd),
        .status      (status),
        .row_enable  (row_enable),
        .column_bits (column_bits)
    );

    assign m_tdata = {column_bits, row_enable};

endmodule : led_matrix_frame_scanner

`default_nettype wire
